// File: sv/sbef_pkg.sv
// shared types, codes and constants of the sender blocklist expiry filter
package sbef_pkg;

  // default number of table entries
  localparam int DEF_TABLE_ENTRIES = 64;

  localparam int ACTION_W   = 2;
  localparam int KEY_UP_W   = 32;
  localparam int KEY_LO_W   = 64;
  localparam int TIME_W     = 64;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RSVD      = 2'd3
  } status_e;

  // one table entry as held in the ram, key_upper in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0]   expiry;
    logic [KEY_LO_W-1:0] key_lower;
    logic [KEY_UP_W-1:0] key_upper;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch the request, restart the scan
    logic scan;    // step the table scan
    logic finish;  // commit table update and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;  // offered request must search the table
    logic scan_done;   // match found or last entry compared
    logic out_free;    // result register can take a new result
  } stat_t;

endpackage

// File: sv/sbef_ram.sv
// generic simple dual-port ram with registered read
module sbef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sbef_datapath.sv
// datapath: request registers, table scan, entry count and result register
module sbef_datapath #(
  parameter int TABLE_ENTRIES = sbef_pkg::DEF_TABLE_ENTRIES,
  localparam int CW = $clog2(TABLE_ENTRIES + 1),
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sbef_pkg::cmd_t                  cmd_i,
  output sbef_pkg::stat_t                 stat_o,
  input  logic [sbef_pkg::ACTION_W-1:0]   in_action_i,
  input  logic [sbef_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [sbef_pkg::OUT_DATA_W-1:0] out_data_o
);

  sbef_pkg::action_e act_q;
  sbef_pkg::entry_t  req_q;
  sbef_pkg::entry_t  rd_entry;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_idx_q;
  logic          cmp_pend_q;
  logic          cmp_last_q;
  logic          hit_q;
  logic          blocked_q;
  logic          issue;
  logic          match;
  logic          full;
  logic          do_write;

  logic                            out_valid_q;
  logic [sbef_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                            drop;
  logic                            expired;
  sbef_pkg::status_e               status;

  // the table: key and expiry of each entry side by side
  sbef_ram #(
    .WIDTH (sbef_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (req_q),
    .raddr_i (issue_idx_q[IW-1:0]),
    .rdata_o (rd_entry)
  );

  assign full  = (count_q == CW'(TABLE_ENTRIES));
  assign issue = cmd_i.scan && (issue_idx_q < count_q);
  assign match = cmp_pend_q
                 && (rd_entry.key_lower == req_q.key_lower)
                 && (rd_entry.key_upper == req_q.key_upper);

  assign stat_o.needs_scan = ((in_action_i == sbef_pkg::ACT_INSERT)
                              || (in_action_i == sbef_pkg::ACT_LOOKUP))
                             && (count_q != '0);
  assign stat_o.scan_done  = match || (cmp_pend_q && cmp_last_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q           <= sbef_pkg::action_e'(in_action_i);
      req_q.key_upper <= in_data_i[sbef_pkg::KEY_UP_W-1:0];
      req_q.key_lower <= in_data_i[sbef_pkg::KEY_UP_W +: sbef_pkg::KEY_LO_W];
      req_q.expiry    <= in_data_i[sbef_pkg::KEY_UP_W + sbef_pkg::KEY_LO_W
                                   +: sbef_pkg::TIME_W];
    end
  end

  // scan: one read issued per cycle, compared in the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q <= '0;
      cmp_pend_q  <= 1'b0;
      cmp_last_q  <= 1'b0;
      hit_q       <= 1'b0;
      blocked_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      issue_idx_q <= '0;
      cmp_pend_q  <= 1'b0;
      cmp_last_q  <= 1'b0;
      hit_q       <= 1'b0;
      blocked_q   <= 1'b0;
    end else if (cmd_i.scan) begin
      cmp_pend_q <= issue;
      if (issue) begin
        issue_idx_q <= issue_idx_q + CW'(1);
        cmp_last_q  <= (issue_idx_q == (count_q - CW'(1)));
      end
      if (match) begin
        hit_q     <= 1'b1;
        // the req expiry field holds the current time on a lookup
        blocked_q <= (req_q.expiry < rd_entry.expiry);
      end
    end
  end

  // result and table update
  assign do_write = cmd_i.finish && (act_q == sbef_pkg::ACT_INSERT) && !hit_q && !full;

  always_comb begin
    drop    = 1'b0;
    expired = 1'b0;
    status  = sbef_pkg::STAT_OK;
    count_d = count_q;
    unique case (act_q)
      sbef_pkg::ACT_CLEAR: begin
        count_d = '0;
      end
      sbef_pkg::ACT_INSERT: begin
        if (hit_q) begin
          status = sbef_pkg::STAT_DUPLICATE;
        end else if (full) begin
          status = sbef_pkg::STAT_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      sbef_pkg::ACT_LOOKUP: begin
        drop    = hit_q && blocked_q;
        expired = hit_q && !blocked_q;
      end
      default: begin
      end
    endcase
    out_data_d = {5'd0, sbef_pkg::COUNT_W'(count_d), status, expired, drop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/sbef_ctrl.sv
// controller state machine: accept, scan, finish
module sbef_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sbef_pkg::stat_t stat_i,
  output sbef_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.scan    = 1'b0;
    cmd_o.finish  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = stat_i.needs_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait here while the previous result is still held
        cmd_o.finish = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/sender_blocklist_expiry_filter.sv
// top level of the sender blocklist expiry filter
//
// a table of up to TABLE_ENTRIES blocked 96-bit sender prefixes with expiry times
// requests come in on the s_axis channel: the action (clear, insert, lookup) in
// tuser, key and time in tdata; every request gives exactly one result on m_axis
// lookup: drop while time is before the matching entry's expiry, else allow and
// flag expired_hit; no match allows; insert ignores a present key (status
// duplicate) or a full table (status full); clear empties the table
// one request at a time: s_axis_tready is high only in the idle state
// clear, an unused action or an empty table skip the scan and go straight to
// finish; otherwise a scan reads one entry per cycle from the table ram and
// stops at a match or after the last held entry compared; the block returns
// to idle as the result is loaded, and the next request is taken from there
// the result sits in an output register, so the next request is accepted while
// it waits; if the receiver stalls, a finished request holds until it is taken
// reset empties the table (entry count zero) at once, no clearing pass; entry
// contents stay undefined until inserted and are never read before that
module sender_blocklist_expiry_filter #(
  parameter int TABLE_ENTRIES = sbef_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_upper[31:0], key_lower[95:32], time_value[159:96]
  input  logic [sbef_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [sbef_pkg::ACTION_W-1:0]   s_axis_tuser,
  // result channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // drop[0], expired_hit[1], status[3:2], entry_count[10:4], zero[15:11]
  output logic [sbef_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  sbef_pkg::cmd_t  cmd;
  sbef_pkg::stat_t stat;

  // sequencing of accept, scan and finish
  sbef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, compare, count and result register
  sbef_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_action_i (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: verif/tb_sender_blocklist_expiry_filter.sv
// self-checking testbench of the sender blocklist expiry filter
`timescale 1ns / 100ps

module tb_sender_blocklist_expiry_filter;

  localparam int TB_ENTRIES  = sbef_pkg::DEF_TABLE_ENTRIES;
  localparam int DRAIN_LIMIT = 50000;

  // one predicted result, in the order the fields sit in m_axis_tdata
  typedef struct {
    logic              drop;
    logic              expired;
    sbef_pkg::status_e status;
    logic [6:0]        count;
  } verdict_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // key_upper[31:0], key_lower[95:32], time_value[159:96]
  logic [sbef_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  // action[1:0]
  logic [sbef_pkg::ACTION_W-1:0]   s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // drop[0], expired_hit[1], status[3:2], entry_count[10:4], zero[15:11]
  logic [sbef_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // predictor copy of the blocklist, key kept as {upper, lower}
  logic [95:0] blk_key    [TB_ENTRIES];
  logic [63:0] blk_expiry [TB_ENTRIES];
  int          held_entries = 0;

  verdict_t    pending_verdicts[$];
  logic [95:0] seen_keys[$];

  // random idling on both sides, switched off near the end
  bit          idle_enable = 1'b1;
  int unsigned stall_left = 0;

  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned drops_seen = 0;
  int unsigned expired_seen = 0;
  int unsigned dups_seen = 0;
  int unsigned full_seen = 0;

  sender_blocklist_expiry_filter #(
    .TABLE_ENTRIES(TB_ENTRIES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #(64'd10_000_000);
    $display("%0t: run timed out", $time);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [95:0] rand_key();
    return {$urandom, $urandom, $urandom};
  endfunction

  // times on both sides of an expiry, plus the extremes
  function automatic logic [63:0] probe_time(logic [63:0] expiry);
    case ($urandom_range(0, 5))
      0: return expiry - 64'd1;
      1: return expiry;
      2: return expiry + 64'd1;
      3: return 64'd0;
      4: return '1;
      default: return rand_word();
    endcase
  endfunction

  // updates the table copy for one request and returns its verdict
  function automatic verdict_t apply_blocklist_request(sbef_pkg::action_e act,
                                                       logic [95:0] key,
                                                       logic [63:0] tv);
    verdict_t v;
    int hit;
    v.drop    = 1'b0;
    v.expired = 1'b0;
    v.status  = sbef_pkg::STAT_OK;
    hit = -1;
    for (int i = 0; i < held_entries; i++) begin
      if (hit < 0 && blk_key[i] == key) hit = i;
    end
    case (act)
      sbef_pkg::ACT_CLEAR: held_entries = 0;
      sbef_pkg::ACT_INSERT: begin
        // duplicate check comes before the full check
        if (hit >= 0) begin
          v.status = sbef_pkg::STAT_DUPLICATE;
        end else if (held_entries >= TB_ENTRIES) begin
          v.status = sbef_pkg::STAT_FULL;
        end else begin
          blk_key[held_entries]    = key;
          blk_expiry[held_entries] = tv;
          held_entries++;
        end
      end
      sbef_pkg::ACT_LOOKUP: begin
        // blocked only while strictly before expiry
        if (hit >= 0) begin
          if (tv < blk_expiry[hit]) v.drop = 1'b1;
          else v.expired = 1'b1;
        end
      end
      default: ;
    endcase
    v.count = 7'(held_entries);
    return v;
  endfunction

  // hand one request to the block, optionally after an idle burst
  task automatic post_request(sbef_pkg::action_e act, logic [95:0] key, logic [63:0] tv);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tv, key[63:0], key[95:64]};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pending_verdicts.push_back(apply_blocklist_request(act, key, tv));
    if (act == sbef_pkg::ACT_INSERT) begin
      seen_keys.push_back(key);
      if (seen_keys.size() > 256) void'(seen_keys.pop_front());
    end
    requests_sent++;
  endtask

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result checker and receiver stall generator
  always @(posedge clk_i) begin : result_monitor
    verdict_t want;
    logic [sbef_pkg::OUT_DATA_W-1:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result %h with no request pending", $time, got);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        check_field("drop", 7'(want.drop), 7'(got[0]));
        check_field("expired_hit", 7'(want.expired), 7'(got[1]));
        check_field("status", 7'(want.status), 7'(got[3:2]));
        check_field("entry_count", want.count, got[10:4]);
        check_field("padding", 7'd0, 7'(got[15:11]));
        if (want.drop) drops_seen++;
        if (want.expired) expired_seen++;
        if (want.status == sbef_pkg::STAT_DUPLICATE) dups_seen++;
        if (want.status == sbef_pkg::STAT_FULL) full_seen++;
      end
    end
    // stall bursts of random length
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // empty table, key extremes and the expiry boundary
  task automatic test_lookup_basics();
    logic [95:0] near_key;
    near_key = {32'h0000_0001, 64'h0000_0000_0000_1234};
    post_request(sbef_pkg::ACT_LOOKUP, '0, '0);
    post_request(sbef_pkg::ACT_INSERT, '0, '0);
    post_request(sbef_pkg::ACT_LOOKUP, '0, '0);    // expiry zero never blocks
    post_request(sbef_pkg::ACT_INSERT, '1, '1);
    post_request(sbef_pkg::ACT_LOOKUP, '1, '1);    // at expiry: allowed, expired
    post_request(sbef_pkg::ACT_LOOKUP, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    post_request(sbef_pkg::ACT_INSERT, '1, '0);    // first insert wins
    post_request(sbef_pkg::ACT_LOOKUP, '1, '0);
    post_request(sbef_pkg::ACT_INSERT, near_key, 64'd1000);
    post_request(sbef_pkg::ACT_LOOKUP, near_key, 64'd999);
    post_request(sbef_pkg::ACT_LOOKUP, near_key, 64'd1000);
    post_request(sbef_pkg::ACT_LOOKUP, near_key, 64'd1001);
    post_request(sbef_pkg::ACT_LOOKUP, near_key ^ (96'd1 << 95), 64'd0);
    post_request(sbef_pkg::ACT_LOOKUP, near_key ^ (96'd1 << 64), 64'd0);
  endtask

  // clear and refill of the first slot
  task automatic test_clear_table();
    post_request(sbef_pkg::ACT_CLEAR, rand_key(), rand_word());
    post_request(sbef_pkg::ACT_LOOKUP, '1, '0);
    post_request(sbef_pkg::ACT_INSERT, 96'h5A5A, 64'd77);
    post_request(sbef_pkg::ACT_LOOKUP, 96'h5A5A, 64'd0);
  endtask

  // the spare action code leaves the table alone
  task automatic test_unused_action();
    post_request(sbef_pkg::ACT_NONE, rand_key(), rand_word());
    post_request(sbef_pkg::ACT_NONE, 96'h5A5A, '1);
    post_request(sbef_pkg::ACT_LOOKUP, 96'h5A5A, 64'd76);
  endtask

  // fill to capacity, then full, duplicate while full, deepest match
  task automatic test_table_full();
    post_request(sbef_pkg::ACT_CLEAR, '0, '0);
    for (int n = 0; n < TB_ENTRIES; n++) begin
      post_request(sbef_pkg::ACT_INSERT, rand_key(), rand_word());
    end
    post_request(sbef_pkg::ACT_INSERT, rand_key(), rand_word());
    post_request(sbef_pkg::ACT_INSERT, blk_key[0], rand_word());
    post_request(sbef_pkg::ACT_LOOKUP, blk_key[TB_ENTRIES-1],
                 probe_time(blk_expiry[TB_ENTRIES-1]));
    post_request(sbef_pkg::ACT_LOOKUP, blk_key[0], probe_time(blk_expiry[0]));
    post_request(sbef_pkg::ACT_LOOKUP, rand_key(), rand_word());
    post_request(sbef_pkg::ACT_CLEAR, '0, '0);
  endtask

  // mostly lookups of held keys near their expiry, inserts and some noise
  task automatic test_random(int unsigned n_items);
    int unsigned       r;
    int unsigned       slot;
    logic [95:0]       key;
    logic [63:0]       tv;
    sbef_pkg::action_e act;
    for (int unsigned k = 0; k < n_items; k++) begin
      idle_enable = (k + 80 < n_items);
      r = $urandom_range(0, 99);
      if (r < 1) act = sbef_pkg::ACT_CLEAR;
      else if (r < 4) act = sbef_pkg::ACT_NONE;
      else if (r < 44) act = sbef_pkg::ACT_INSERT;
      else act = sbef_pkg::ACT_LOOKUP;
      key = rand_key();
      tv  = rand_word();
      r = $urandom_range(0, 99);
      if (act == sbef_pkg::ACT_LOOKUP) begin
        if (held_entries > 0 && r < 60) begin
          slot = $urandom_range(0, held_entries - 1);
          key  = blk_key[slot];
          tv   = probe_time(blk_expiry[slot]);
        end else if (held_entries > 0 && r < 70) begin
          // near miss: one bit off a held key
          slot = $urandom_range(0, held_entries - 1);
          key  = blk_key[slot] ^ (96'd1 << $urandom_range(0, 95));
        end else if (seen_keys.size() > 0 && r < 85) begin
          key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        end
      end else if (act == sbef_pkg::ACT_INSERT) begin
        if (held_entries > 0 && r >= 70 && r < 85) begin
          key = blk_key[$urandom_range(0, held_entries - 1)];
        end else if (seen_keys.size() > 0 && r >= 85) begin
          key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        end
        case ($urandom_range(0, 4))
          0: tv = '0;
          1: tv = '1;
          2: tv = {32'd0, $urandom};
          default: ;
        endcase
      end
      post_request(act, key, tv);
    end
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lookup_basics();
    test_clear_table();
    test_unused_action();
    test_table_full();
    test_random(320);
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then let the block settle
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      error_count++;
    end
    repeat (TB_ENTRIES + 8) @(posedge clk_i);

    $display("sent %0d requests, checked %0d results, %0d mismatches", requests_sent,
             results_checked, error_count);
    $display("verdicts: %0d drops, %0d expired hits, %0d duplicates, %0d table full",
             drops_seen, expired_seen, dups_seen, full_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
